[sv/pmu_pkg.sv]
// Shared sizes, command codes, term descriptor and helper functions for the
// polynomial multiplier unit. No dependencies.
`timescale 1ns / 1ps

package pmu_pkg;

  localparam int MAX_DEGREE  = 15;
  localparam int COEFF_WIDTH = 16;
  localparam int DEPTH       = MAX_DEGREE + 1;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int K_W         = $clog2(2 * MAX_DEGREE + 1);
  localparam int PROD_W      = 2 * COEFF_WIDTH;
  localparam int OUT_W       = 36;
  localparam int OUT_IDX_W   = 5;

  typedef enum logic [1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_B  = 2'd1,
    CMD_COMPUTE = 2'd2
  } cmd_t;

  // One multiply-accumulate term as issued by the sequencer.
  typedef struct packed {
    logic              valid;
    logic              first;
    logic              last_term;
    logic              last_k;
    logic [K_W-1:0]    k;
    logic [ADDR_W-1:0] a_addr;
    logic [ADDR_W-1:0] b_addr;
  } term_t;

  // Degrees above MAX_DEGREE saturate to the top entry.
  function automatic logic [ADDR_W-1:0] clamp_deg(input logic [3:0] d);
    if (int'(d) > MAX_DEGREE) begin
      return ADDR_W'(MAX_DEGREE);
    end else begin
      return ADDR_W'(d);
    end
  endfunction

  function automatic logic index_in_range(input logic [3:0] d);
    return int'(d) <= MAX_DEGREE;
  endfunction

endpackage

[sv/pmu_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module pmu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/pmu_seq.sv]
// Term sequencer: walks k over the product degrees and i over the valid
// terms of each k. Depends on pmu_pkg.
`timescale 1ns / 1ps

module pmu_seq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [3:0]                deg_a,
  input  logic [3:0]                deg_b,
  input  logic                      adv,
  output pmu_pkg::term_t            iss,
  output logic                      busy
);
  import pmu_pkg::*;

  logic              active_r, active_nxt;
  logic [K_W-1:0]    k_r, k_nxt;
  logic [ADDR_W-1:0] i_r, i_nxt;
  logic [ADDR_W-1:0] da_r, da_nxt;
  logic [ADDR_W-1:0] db_r, db_nxt;
  logic [K_W-1:0]    top_r, top_nxt;

  logic [ADDR_W-1:0] i_lo, i_hi, i_lo_next;
  logic [K_W-1:0]    k_inc;

  always_comb begin
    k_inc     = k_r + K_W'(1);
    i_lo      = (k_r > K_W'(db_r)) ? ADDR_W'(k_r - K_W'(db_r)) : '0;
    i_hi      = (k_r > K_W'(da_r)) ? da_r : ADDR_W'(k_r);
    i_lo_next = (k_inc > K_W'(db_r)) ? ADDR_W'(k_inc - K_W'(db_r)) : '0;
  end

  always_comb begin
    iss.valid     = active_r;
    iss.first     = (i_r == i_lo);
    iss.last_term = (i_r == i_hi);
    iss.last_k    = (k_r == top_r);
    iss.k         = k_r;
    iss.a_addr    = i_r;
    iss.b_addr    = ADDR_W'(k_r - K_W'(i_r));
  end

  always_comb begin
    active_nxt = active_r;
    k_nxt      = k_r;
    i_nxt      = i_r;
    da_nxt     = da_r;
    db_nxt     = db_r;
    top_nxt    = top_r;
    if (start) begin
      active_nxt = 1'b1;
      k_nxt      = '0;
      i_nxt      = '0;
      da_nxt     = clamp_deg(deg_a);
      db_nxt     = clamp_deg(deg_b);
      top_nxt    = K_W'(clamp_deg(deg_a)) + K_W'(clamp_deg(deg_b));
    end else if (active_r && adv) begin
      if (i_r == i_hi) begin
        if (k_r == top_r) begin
          active_nxt = 1'b0;
        end else begin
          k_nxt = k_inc;
          i_nxt = i_lo_next;
        end
      end else begin
        i_nxt = i_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
    k_r   <= k_nxt;
    i_r   <= i_nxt;
    da_r  <= da_nxt;
    db_r  <= db_nxt;
    top_r <= top_nxt;
  end

  assign busy = active_r;

endmodule

[sv/pmu_mac.sv]
// Multiply-accumulate pipeline behind the coefficient RAMs, ending in the
// result output register. Depends on pmu_pkg.
`timescale 1ns / 1ps

module pmu_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pmu_pkg::term_t                    iss,
  input  logic                              iss_va,
  input  logic                              iss_vb,
  input  logic [pmu_pkg::COEFF_WIDTH-1:0]   a_data,
  input  logic [pmu_pkg::COEFF_WIDTH-1:0]   b_data,
  input  logic                              out_stall,
  output logic                              adv,
  output logic                              busy,
  output logic                              out_valid,
  output logic [pmu_pkg::OUT_IDX_W-1:0]     out_index,
  output logic signed [pmu_pkg::OUT_W-1:0]  out_coeff,
  output logic                              out_last
);
  import pmu_pkg::*;

  term_t                     s1_r, s2_r;
  logic                      s1_va_r, s1_vb_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [OUT_W-1:0]   acc_r, acc_sum;
  logic signed [COEFF_WIDTH-1:0] a_op, b_op;
  logic                      out_valid_r;
  logic [OUT_IDX_W-1:0]      out_index_r;
  logic signed [OUT_W-1:0]   out_coeff_r;
  logic                      out_last_r;

  // The whole pipeline freezes while a result waits on a stalled receiver.
  assign adv = !(out_valid_r && out_stall);

  // Entries never loaded since reset read as zero.
  assign a_op = s1_va_r ? signed'(a_data) : '0;
  assign b_op = s1_vb_r ? signed'(b_data) : '0;

  assign acc_sum = (s2_r.first ? '0 : acc_r) + OUT_W'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid  <= 1'b0;
      s2_r.valid  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_r.valid  <= iss.valid;
      s2_r.valid  <= s1_r.valid;
      if (s2_r.valid && s2_r.last_term) begin
        out_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
    if (adv) begin
      s1_r.first     <= iss.first;
      s1_r.last_term <= iss.last_term;
      s1_r.last_k    <= iss.last_k;
      s1_r.k         <= iss.k;
      s1_r.a_addr    <= iss.a_addr;
      s1_r.b_addr    <= iss.b_addr;
      s1_va_r        <= iss_va;
      s1_vb_r        <= iss_vb;
      s2_r.first     <= s1_r.first;
      s2_r.last_term <= s1_r.last_term;
      s2_r.last_k    <= s1_r.last_k;
      s2_r.k         <= s1_r.k;
      s2_r.a_addr    <= s1_r.a_addr;
      s2_r.b_addr    <= s1_r.b_addr;
      prod_r         <= a_op * b_op;
      if (s2_r.valid) begin
        acc_r <= acc_sum;
        if (s2_r.last_term) begin
          out_index_r <= OUT_IDX_W'(s2_r.k);
          out_coeff_r <= acc_sum;
          out_last_r  <= s2_r.last_k;
        end
      end
    end
  end

  assign busy      = s1_r.valid || s2_r.valid;
  assign out_valid = out_valid_r;
  assign out_index = out_index_r;
  assign out_coeff = out_coeff_r;
  assign out_last  = out_last_r;

endmodule

[sv/polynomial_multiplier_unit.sv]
// Top level of the polynomial multiplier unit: coefficient stores, valid
// bits, sequencer and MAC pipeline. Depends on pmu_pkg, pmu_ram, pmu_seq, pmu_mac.
`timescale 1ns / 1ps

// How to use this block:
// The input channel (in_valid / in_stall) carries three kinds of item. A load
// of A or B writes one signed Q8.8 coefficient at in_index; while no product
// is in progress, loads stream at one transfer per cycle. A load at an index past the
// store is dropped, as is the unused command code.
// A compute item starts a product of degrees in_deg_a and in_deg_b (each
// saturated to the store size). The result channel (out_valid / out_stall)
// then delivers coefficients 0 to deg_a+deg_b in order, each a full-precision
// Q20.16 sum, with out_last set on the highest one.
// Without receiver stalls, one term issues per cycle through the single
// multiplier, and each term passes three register stages (RAM read, multiply,
// accumulate into the output register), so the last coefficient reaches the
// output register once all (deg_a+1)*(deg_b+1) terms have passed. in_stall
// stays high from the accepted compute until every term has left the
// multiplier pipeline.
// When the receiver stalls, the output register holds its result and the
// whole sequencer and MAC pipeline freeze in place, so no result is lost.
// Reset clears all control state and the per-entry valid bits, so both
// coefficient stores read as zero until loaded.
module polynomial_multiplier_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_cmd,
  input  logic [3:0]                        in_index,
  input  logic signed [15:0]                in_coeff,
  input  logic [3:0]                        in_deg_a,
  input  logic [3:0]                        in_deg_b,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pmu_pkg::OUT_IDX_W-1:0]     out_index,
  output logic signed [pmu_pkg::OUT_W-1:0]  out_coeff,
  output logic                              out_last
);
  import pmu_pkg::*;

  logic                   in_xfer;
  logic                   load_a, load_b, start;
  logic [ADDR_W-1:0]      waddr;
  logic [COEFF_WIDTH-1:0] wdata;
  logic [DEPTH-1:0]       va_r, va_nxt;
  logic [DEPTH-1:0]       vb_r, vb_nxt;
  logic [COEFF_WIDTH-1:0] a_data, b_data;
  term_t                  iss;
  logic                   adv, seq_busy, mac_busy;

  assign in_xfer = in_valid && !in_stall;
  assign load_a  = in_xfer && (in_cmd == CMD_LOAD_A) && index_in_range(in_index);
  assign load_b  = in_xfer && (in_cmd == CMD_LOAD_B) && index_in_range(in_index);
  assign start   = in_xfer && (in_cmd == CMD_COMPUTE);
  assign waddr   = ADDR_W'(in_index);
  assign wdata   = COEFF_WIDTH'(in_coeff);

  // New items wait until the current product has drained the pipeline, so a
  // load can never overwrite an entry that a term still has to read.
  assign in_stall = seq_busy || mac_busy;

  always_comb begin
    va_nxt = va_r;
    vb_nxt = vb_r;
    if (load_a) begin
      va_nxt[waddr] = 1'b1;
    end
    if (load_b) begin
      vb_nxt[waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= '0;
      vb_r <= '0;
    end else begin
      va_r <= va_nxt;
      vb_r <= vb_nxt;
    end
  end

  pmu_ram #(.WIDTH(COEFF_WIDTH), .DEPTH(DEPTH)) u_a_ram (
    .clk   (clk),
    .we    (load_a),
    .waddr (waddr),
    .wdata (wdata),
    .re    (adv),
    .raddr (iss.a_addr),
    .rdata (a_data)
  );

  pmu_ram #(.WIDTH(COEFF_WIDTH), .DEPTH(DEPTH)) u_b_ram (
    .clk   (clk),
    .we    (load_b),
    .waddr (waddr),
    .wdata (wdata),
    .re    (adv),
    .raddr (iss.b_addr),
    .rdata (b_data)
  );

  pmu_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .deg_a (in_deg_a),
    .deg_b (in_deg_b),
    .adv   (adv),
    .iss   (iss),
    .busy  (seq_busy)
  );

  pmu_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .iss       (iss),
    .iss_va    (va_r[iss.a_addr]),
    .iss_vb    (vb_r[iss.b_addr]),
    .a_data    (a_data),
    .b_data    (b_data),
    .out_stall (out_stall),
    .adv       (adv),
    .busy      (mac_busy),
    .out_valid (out_valid),
    .out_index (out_index),
    .out_coeff (out_coeff),
    .out_last  (out_last)
  );

  // A compute transfer must block the input channel on the next cycle.
  a_compute_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> in_stall)
    else $error("input not blocked after compute transfer");

  // While a non-final coefficient is pending, later terms are still in flight.
  a_more_terms: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> in_stall)
    else $error("non-final result with no work left");

  // After the final coefficient transfers, no result follows immediately.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last && !out_stall) |=> !out_valid)
    else $error("result right after final coefficient");

endmodule
